// ----- src/idtb_pkg.sv -----
// Shared types and constants of the isometric diamond tile blitter.
package idtb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [1:0] SIZE_SMALL  = 2'd0;
    localparam logic [1:0] SIZE_MEDIUM = 2'd1;

    localparam logic [1:0] PART_TOP    = 2'd1;
    localparam logic [1:0] PART_BOTTOM = 2'd2;

    localparam logic [1:0] HALF_FULL   = 2'd0;
    localparam logic [1:0] HALF_LEFT   = 2'd1;

    localparam logic [4:0] HEIGHT_SMALL  = 5'd6;
    localparam logic [4:0] HEIGHT_MEDIUM = 5'd14;
    localparam logic [4:0] HEIGHT_LARGE  = 5'd30;

    localparam logic CFG_FRAME_BASE = 1'b0;
    localparam logic CFG_LINE_PITCH = 1'b1;

    localparam logic [23:0] FRAME_BASE_RESET = 24'd0;
    localparam logic [12:0] LINE_PITCH_RESET = 13'd640;

    typedef struct packed {
        logic [7:0]  pixel;
        logic        first;
        logic        emit;
        logic [4:0]  row;
        logic [5:0]  col;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
    } queue_entry_t;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
        logic                   full;
        logic                   empty;
    } queue_status_t;

endpackage

// ----- src/idtb_front.sv -----
// Front end: tracks row and column of the tile and classifies each source item.
module idtb_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            pixel,
    input  logic                  first,
    input  logic [1:0]            tile_size,
    input  logic [1:0]            part,
    input  logic [1:0]            half,
    input  logic [11:0]           dest_x,
    input  logic [11:0]           dest_y,
    output logic                  push,
    output idtb_pkg::queue_entry_t entry
);

    logic [4:0] row_reg, row_next;
    logic [5:0] col_reg, col_next;
    logic [5:0] mode_reg, mode_next;

    logic       fire;
    logic [1:0] size_m, part_m, half_m;
    logic [4:0] r_cur, height, half_h;
    logic [5:0] c_cur, full_w, left, lvl2, col_out;
    logic [3:0] level;
    logic       in_rows, emit, live, row_end;

    assign fire = in_valid && in_ready;

    always_comb begin
        mode_next = first ? {half, part, tile_size} : mode_reg;
        r_cur     = first ? 5'd0 : row_reg;
        c_cur     = first ? 6'd0 : col_reg;
        size_m    = mode_next[1:0];
        part_m    = mode_next[3:2];
        half_m    = mode_next[5:4];
        unique case (size_m)
            idtb_pkg::SIZE_SMALL:  height = idtb_pkg::HEIGHT_SMALL;
            idtb_pkg::SIZE_MEDIUM: height = idtb_pkg::HEIGHT_MEDIUM;
            default:               height = idtb_pkg::HEIGHT_LARGE;
        endcase
        half_h  = height >> 1;
        live    = r_cur < height;
        level   = (r_cur < half_h) ? r_cur[3:0] : 4'(height - r_cur - 5'd1);
        lvl2    = {1'b0, level, 1'b0};
        full_w  = {level, 2'b10};
        left    = 6'(height) - 6'd2 - lvl2;
        in_rows = (part_m != idtb_pkg::PART_BOTTOM || r_cur >= half_h)
               && (part_m != idtb_pkg::PART_TOP || r_cur < half_h);
        emit    = 1'b0;
        col_out = left + c_cur;
        if (half_m == idtb_pkg::HALF_FULL) begin
            emit = in_rows;
        end else if (level != 4'd0 && (size_m == idtb_pkg::SIZE_SMALL || in_rows)) begin
            if (half_m == idtb_pkg::HALF_LEFT) begin
                emit    = c_cur >= lvl2 + 6'd2;
                col_out = c_cur - (lvl2 + 6'd2);
            end else begin
                emit = c_cur < lvl2;
            end
        end
        emit    = emit && live;
        row_end = ({1'b0, c_cur} + 7'd1) >= {1'b0, full_w};
        row_next = r_cur;
        col_next = c_cur;
        if (live) begin
            if (row_end) begin
                col_next = 6'd0;
                row_next = r_cur + 5'd1;
            end else begin
                col_next = c_cur + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= 5'd0;
            col_reg  <= 6'd0;
            mode_reg <= 6'd0;
        end else if (fire) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            mode_reg <= mode_next;
        end
    end

    assign push         = fire && (emit || first);
    assign entry.pixel  = pixel;
    assign entry.first  = first;
    assign entry.emit   = emit;
    assign entry.row    = r_cur;
    assign entry.col    = col_out;
    assign entry.dest_x = dest_x;
    assign entry.dest_y = dest_y;

endmodule

// ----- src/idtb_queue.sv -----
// Short first-in first-out queue between the front end and the back end.
module idtb_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  idtb_pkg::queue_entry_t push_entry,
    input  logic                   pop,
    output idtb_pkg::queue_entry_t pop_entry,
    output idtb_pkg::queue_status_t status
);

    idtb_pkg::queue_entry_t entries_reg [idtb_pkg::QUEUE_DEPTH];
    logic [idtb_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [idtb_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [idtb_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = count_reg == idtb_pkg::QUEUE_CNT_W'(idtb_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/idtb_back.sv -----
// Back end: configuration registers, tile origin and framebuffer address pipeline.
module idtb_back #(
    parameter int ROW_STRIDE = 640,
    parameter int ADDR_BITS  = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [23:0]            cfg_wdata,
    input  idtb_pkg::queue_entry_t q_entry,
    input  logic                   q_valid,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [23:0]            out_address,
    output logic [7:0]             out_pixel
);

    localparam int AW = (ADDR_BITS < 24) ? ADDR_BITS : 24;

    logic [23:0]   frame_base_reg;
    logic [12:0]   line_pitch_reg;
    logic [AW-1:0] tile_base_reg;

    logic          a_valid_reg;
    logic          a_first_reg;
    logic          a_emit_reg;
    logic [7:0]    a_pixel_reg;
    logic [24:0]   a_prod_reg;
    logic [AW-1:0] a_xb_reg;
    logic [AW-1:0] a_off_reg;

    logic          m_valid_reg;
    logic [23:0]   m_address_reg;
    logic [7:0]    m_pixel_reg;

    logic          a_adv;
    logic [AW-1:0] base_new, base_sel, addr_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= idtb_pkg::FRAME_BASE_RESET;
            line_pitch_reg <= idtb_pkg::LINE_PITCH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                idtb_pkg::CFG_FRAME_BASE: frame_base_reg <= cfg_wdata;
                idtb_pkg::CFG_LINE_PITCH: line_pitch_reg <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    assign a_adv = !m_valid_reg || out_ready;
    assign q_pop = q_valid && (!a_valid_reg || a_adv);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_first_reg <= q_entry.first;
            a_emit_reg  <= q_entry.emit;
            a_pixel_reg <= q_entry.pixel;
            a_prod_reg  <= 25'(q_entry.dest_y) * 25'(line_pitch_reg);
            a_xb_reg    <= frame_base_reg[AW-1:0] + AW'(q_entry.dest_x);
            a_off_reg   <= AW'(32'(q_entry.row) * 32'(ROW_STRIDE)) + AW'(q_entry.col);
        end
    end

    always_comb begin
        base_new = a_xb_reg + AW'(a_prod_reg);
        base_sel = a_first_reg ? base_new : tile_base_reg;
        addr_sum = base_sel + a_off_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            tile_base_reg <= '0;
        end else begin
            if (q_pop) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_valid_reg && a_adv) begin
                if (a_first_reg) begin
                    tile_base_reg <= base_new;
                end
                m_valid_reg <= a_emit_reg;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && a_adv && a_emit_reg) begin
            m_address_reg <= 24'(addr_sum);
            m_pixel_reg   <= a_pixel_reg;
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_address = m_address_reg;
    assign out_pixel   = m_pixel_reg;

endmodule

// ----- src/isometric_diamond_tile_blit_top.sv -----
// Top level of the isometric diamond tile blitter.
//
//   Port group   Direction   Carries
//   s_*          in          source items: pixel, tile start, mode, origin
//   m_*          out         framebuffer writes: address and pixel
//   cfg_*        in          register writes: frame base, line pitch
//
// One source item is accepted every cycle while the four-entry queue has room.
// A written pixel is offered on m_ once it has passed its queue slot,
// the address stage and the output register, in that order.
// Reset is synchronous and active low and clears counters, queue and tile origin.
// A stall on m_ fills the queue and only then drops s_tready.
module isometric_diamond_tile_blit_top #(
    parameter int ROW_STRIDE = 640,
    parameter int ADDR_BITS  = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel[7:0], dest_x[19:8], dest_y[31:20]
    input  logic [6:0]  s_tuser,   // first[0], tile_size[2:1], part[4:3], half[6:5]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // address[23:0], pixel_out[31:24]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata
);

    logic                    push, pop;
    idtb_pkg::queue_entry_t  push_entry, pop_entry;
    idtb_pkg::queue_status_t q_status;
    logic [23:0]             address;
    logic [7:0]              pixel_out;

    assign s_tready = !q_status.full;

    idtb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pixel     (s_tdata[7:0]),
        .first     (s_tuser[0]),
        .tile_size (s_tuser[2:1]),
        .part      (s_tuser[4:3]),
        .half      (s_tuser[6:5]),
        .dest_x    (s_tdata[19:8]),
        .dest_y    (s_tdata[31:20]),
        .push      (push),
        .entry     (push_entry)
    );

    idtb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    idtb_back #(
        .ROW_STRIDE (ROW_STRIDE),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .q_entry     (pop_entry),
        .q_valid     (!q_status.empty),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_address (address),
        .out_pixel   (pixel_out)
    );

    assign m_tdata = {pixel_out, address};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= idtb_pkg::QUEUE_CNT_W'(idtb_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_status.full && !pop) |=> q_status.count == $past(q_status.count) + 1'b1)
        else $error("queue did not grow on a push without a pop");

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("back end popped an empty queue");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while it waited");
`endif

endmodule
